// ----- rtl/dhcprp_pkg.sv -----
// shared types, constants and helpers of the dhcp reply parser
package dhcprp_pkg;

   // default packet layout
   localparam int HeaderBytesDefault = 44;
   localparam int OptionStartDefault = 240;

   // configuration port geometry
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 64;
   localparam logic [1:0] REG_CLIENT_MAC = 2'd0;
   localparam logic [1:0] REG_XID_FIRST  = 2'd1;
   localparam logic [1:0] REG_XID_LAST   = 2'd2;

   // header values
   localparam logic [7:0] OP_BOOT_REPLY = 8'd2;

   // option codes
   localparam logic [7:0] OPT_PAD         = 8'd0;
   localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
   localparam logic [7:0] OPT_ROUTER      = 8'd3;
   localparam logic [7:0] OPT_DNS         = 8'd6;
   localparam logic [7:0] OPT_LEASE_TIME  = 8'd51;
   localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID   = 8'd54;
   localparam logic [7:0] OPT_RENEW_TIME  = 8'd58;
   localparam logic [7:0] OPT_REBIND_TIME = 8'd59;
   localparam logic [7:0] OPT_END         = 8'd255;

   // kept field slots
   localparam logic [2:0] SLOT_OFFERED = 3'd0;
   localparam logic [2:0] SLOT_MASK    = 3'd1;
   localparam logic [2:0] SLOT_GATEWAY = 3'd2;
   localparam logic [2:0] SLOT_DNS     = 3'd3;
   localparam logic [2:0] SLOT_SERVER  = 3'd4;
   localparam logic [2:0] SLOT_RENEW   = 3'd5;
   localparam logic [2:0] SLOT_REBIND  = 3'd6;
   localparam logic [2:0] SLOT_LEASE   = 3'd7;

   // configuration registers as seen by the parser
   typedef struct packed {
      logic [47:0] client_mac;
      logic [31:0] xid_first;
      logic [31:0] xid_last;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [7:0][31:0] kept;
      logic [31:0]      reply_xid;
      logic [7:0]       message_type;
   } result_type;

   // slot lookup for an option code: {hit, slot}
   function automatic logic [3:0] slot_of(input logic [7:0] code);
      logic [3:0] res;
      res = 4'd0;
      case (code)
         OPT_SUBNET_MASK: res = {1'b1, SLOT_MASK};
         OPT_ROUTER:      res = {1'b1, SLOT_GATEWAY};
         OPT_DNS:         res = {1'b1, SLOT_DNS};
         OPT_SERVER_ID:   res = {1'b1, SLOT_SERVER};
         OPT_RENEW_TIME:  res = {1'b1, SLOT_RENEW};
         OPT_REBIND_TIME: res = {1'b1, SLOT_REBIND};
         OPT_LEASE_TIME:  res = {1'b1, SLOT_LEASE};
         default:         res = 4'd0;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/dhcprp_csr.sv -----
// configuration registers behind the apb-style port
module dhcprp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dhcprp_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [dhcprp_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [dhcprp_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                               csr_pready,
   output dhcprp_pkg::cfg_type                cfg
);

   logic [47:0] client_mac_ff;
   logic [31:0] xid_first_ff;
   logic [31:0] xid_last_ff;
   logic        write_en;
   logic [1:0]  reg_index;

   // register index from the 8-byte aligned address
   assign reg_index  = csr_paddr[4:3];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         client_mac_ff <= '0;
         xid_first_ff  <= '0;
         xid_last_ff   <= '0;
      end else if (write_en) begin
         case (reg_index)
            dhcprp_pkg::REG_CLIENT_MAC: client_mac_ff <= csr_pwdata[47:0];
            dhcprp_pkg::REG_XID_FIRST:  xid_first_ff  <= csr_pwdata[31:0];
            dhcprp_pkg::REG_XID_LAST:   xid_last_ff   <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         dhcprp_pkg::REG_CLIENT_MAC: csr_prdata = {16'd0, client_mac_ff};
         dhcprp_pkg::REG_XID_FIRST:  csr_prdata = {32'd0, xid_first_ff};
         dhcprp_pkg::REG_XID_LAST:   csr_prdata = {32'd0, xid_last_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg.client_mac = client_mac_ff;
   assign cfg.xid_first  = xid_first_ff;
   assign cfg.xid_last   = xid_last_ff;

endmodule

// ----- rtl/dhcprp_parse.sv -----
// per-byte header check and option parser with the kept lease fields
module dhcprp_parse #(
   parameter int HEADER_BYTES = dhcprp_pkg::HeaderBytesDefault,
   parameter int OPTION_START = dhcprp_pkg::OptionStartDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dhcprp_pkg::cfg_type    cfg,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   last_byte,
   input  logic                   from_server_port,
   input  logic [31:0]            sender_ip,
   output logic                   result_load,
   output dhcprp_pkg::result_type result
);

   localparam logic [7:0] HdrLastPos = 8'(HEADER_BYTES - 1);
   localparam logic [7:0] OptStart   = 8'(OPTION_START);

   typedef enum logic [2:0] {
      PH_CODE = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_VAL0 = 3'd3,
      PH_VAL1 = 3'd4,
      PH_VAL2 = 3'd5,
      PH_VAL3 = 3'd6,
      PH_SKIP = 3'd7
   } phase_type;

   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [31:0]      xid_ff, xid_in;
   logic             hw_ff, hw_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       code_ff, code_in;
   logic [7:0]       left_ff, left_in;
   logic [31:0]      vshift_ff, vshift_in;
   logic             accept_ff, accept_in;
   logic [7:0]       found_ff, found_in;
   logic [7:0][31:0] kept_ff, kept_in;

   logic [3:0]       slot;
   logic [2:0]       mac_idx;
   logic [7:0]       mac_byte;
   logic [7:0]       left_dec;
   logic             server_ok;

   assign slot      = dhcprp_pkg::slot_of(code_ff);
   assign mac_idx   = 3'(pos_ff - 8'd28);
   assign mac_byte  = cfg.client_mac[(3'd5 - mac_idx) * 8 +: 8];
   assign left_dec  = (left_ff != 8'd0) ? left_ff - 8'd1 : left_ff;
   assign server_ok = (kept_ff[dhcprp_pkg::SLOT_SERVER][31:24] == 8'd0) ||
                      (kept_ff[dhcprp_pkg::SLOT_SERVER] == sender_ip);

   // next state for one accepted byte
   always_comb begin
      pos_in    = pos_ff;
      opcode_in = opcode_ff;
      xid_in    = xid_ff;
      hw_in     = hw_ff;
      phase_in  = phase_ff;
      code_in   = code_ff;
      left_in   = left_ff;
      vshift_in = vshift_ff;
      accept_in = accept_ff;
      found_in  = found_ff;
      kept_in   = kept_ff;

      if (pos_ff < OptStart) begin
         // fixed header
         if (pos_ff == 8'd0) begin
            opcode_in = rx_byte;
         end
         if (pos_ff >= 8'd4 && pos_ff <= 8'd7) begin
            xid_in = {xid_ff[23:0], rx_byte};
         end
         if (pos_ff >= 8'd16 && pos_ff <= 8'd19) begin
            vshift_in = {vshift_ff[23:0], rx_byte};
         end
         if (pos_ff >= 8'd28 && pos_ff <= 8'd33) begin
            if (rx_byte != mac_byte) hw_in = 1'b0;
         end
         // header verdict
         if (pos_ff == HdrLastPos) begin
            accept_in = (opcode_in == dhcprp_pkg::OP_BOOT_REPLY) && from_server_port &&
                        hw_in && (xid_in >= cfg.xid_first) && (xid_in <= cfg.xid_last);
            if (accept_in) kept_in[dhcprp_pkg::SLOT_OFFERED] = vshift_in;
            vshift_in = '0;
         end
         pos_in = pos_ff + 8'd1;
      end else if (accept_ff) begin
         // option parser
         case (phase_ff)
            PH_CODE: begin
               if (rx_byte != dhcprp_pkg::OPT_PAD) begin
                  code_in  = rx_byte;
                  phase_in = (rx_byte == dhcprp_pkg::OPT_END) ? PH_SKIP : PH_LEN;
               end
            end
            PH_LEN: begin
               vshift_in = '0;
               left_in   = '0;
               if (code_ff == dhcprp_pkg::OPT_MSG_TYPE) begin
                  phase_in = PH_TYPE;
               end else if (code_ff == dhcprp_pkg::OPT_ROUTER ||
                            code_ff == dhcprp_pkg::OPT_DNS) begin
                  left_in  = (rx_byte > 8'd4) ? rx_byte - 8'd4 : 8'd0;
                  phase_in = PH_VAL0;
               end else if (code_ff == dhcprp_pkg::OPT_SERVER_ID) begin
                  if (server_ok) begin
                     phase_in = PH_VAL0;
                  end else begin
                     left_in  = rx_byte;
                     phase_in = (rx_byte != 8'd0) ? PH_SKIP : PH_CODE;
                  end
               end else if (slot[3]) begin
                  phase_in = PH_VAL0;
               end else begin
                  left_in  = rx_byte;
                  phase_in = (rx_byte != 8'd0) ? PH_SKIP : PH_CODE;
               end
            end
            PH_TYPE: begin
               found_in = rx_byte;
               phase_in = PH_CODE;
            end
            PH_SKIP: begin
               // end option parks here for the rest of the packet
               if (code_ff != dhcprp_pkg::OPT_END) begin
                  left_in = left_dec;
                  if (left_dec == 8'd0) phase_in = PH_CODE;
               end
            end
            PH_VAL0: begin
               vshift_in = {vshift_ff[23:0], rx_byte};
               phase_in  = PH_VAL1;
            end
            PH_VAL1: begin
               vshift_in = {vshift_ff[23:0], rx_byte};
               phase_in  = PH_VAL2;
            end
            PH_VAL2: begin
               vshift_in = {vshift_ff[23:0], rx_byte};
               phase_in  = PH_VAL3;
            end
            PH_VAL3: begin
               vshift_in = {vshift_ff[23:0], rx_byte};
               if (slot[3]) kept_in[slot[2:0]] = vshift_in;
               phase_in = (left_ff != 8'd0) ? PH_SKIP : PH_CODE;
            end
            default: phase_in = PH_CODE;
         endcase
      end

      // result from the state after this byte
      result.message_type = accept_in ? found_in : 8'd0;
      result.reply_xid    = xid_in;
      result.kept         = kept_in;

      // end of packet returns packet state to reset values
      if (last_byte) begin
         pos_in    = '0;
         opcode_in = '0;
         xid_in    = '0;
         hw_in     = 1'b1;
         phase_in  = PH_CODE;
         code_in   = '0;
         left_in   = '0;
         vshift_in = '0;
         accept_in = 1'b0;
         found_in  = '0;
      end
   end

   assign result_load = accept & last_byte;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         opcode_ff <= '0;
         xid_ff    <= '0;
         hw_ff     <= 1'b1;
         phase_ff  <= PH_CODE;
         code_ff   <= '0;
         left_ff   <= '0;
         vshift_ff <= '0;
         accept_ff <= 1'b0;
         found_ff  <= '0;
         kept_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         opcode_ff <= opcode_in;
         xid_ff    <= xid_in;
         hw_ff     <= hw_in;
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         left_ff   <= left_in;
         vshift_ff <= vshift_in;
         accept_ff <= accept_in;
         found_ff  <= found_in;
         kept_ff   <= kept_in;
      end
   end

endmodule

// ----- rtl/dhcprp_out.sv -----
// result register with stream handshake toward the consumer
module dhcprp_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   result_load,
   input  dhcprp_pkg::result_type result,
   output logic                   in_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dhcprp_pkg::result_type rsp_result
);

   logic                   valid_ff;
   dhcprp_pkg::result_type data_ff;

   // a new request may enter when the slot is free or drains this cycle
   assign in_ready = ~valid_ff | rsp_tready;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (result_load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ----- rtl/dhcp_reply_parser_unit.sv -----
// top level of the dhcp reply parser
// one request (payload byte) accepted per cycle, back to back, while the result slot
// is free or being drained; the per-byte state update is a single register stage
// the result for a packet is registered and appears in the cycle after its last byte is accepted
// reset (synchronous, active high) clears configuration, packet state and kept fields
module dhcp_reply_parser_unit #(
   parameter int HEADER_BYTES = dhcprp_pkg::HeaderBytesDefault,
   parameter int OPTION_START = dhcprp_pkg::OptionStartDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [39:0]                        req_tdata,  // rx_byte[7:0], sender_ip[39:8]
   input  logic                               req_tlast,
   input  logic                               req_tuser,  // from_server_port
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // message_type[7:0], reply_xid, offered_ip, subnet_mask, gateway_ip, dns_ip,
   // server_ip, renew_time, rebind_time, lease_time (32 bits each, upward)
   output logic [295:0]                       rsp_tdata,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dhcprp_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [dhcprp_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [dhcprp_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                               csr_pready
);

   dhcprp_pkg::cfg_type    cfg;
   dhcprp_pkg::result_type result;
   dhcprp_pkg::result_type rsp_result;
   logic                   result_load;
   logic                   accept;

   assign accept = req_tvalid & req_tready;

   // configuration registers
   dhcprp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // byte parser
   dhcprp_parse #(
      .HEADER_BYTES (HEADER_BYTES),
      .OPTION_START (OPTION_START)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .accept           (accept),
      .rx_byte          (req_tdata[7:0]),
      .last_byte        (req_tlast),
      .from_server_port (req_tuser),
      .sender_ip        (req_tdata[39:8]),
      .result_load      (result_load),
      .result           (result)
   );

   // result register
   dhcprp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .in_ready    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (rsp_result)
   );

   assign rsp_tdata = {rsp_result.kept, rsp_result.reply_xid, rsp_result.message_type};

endmodule
